// ===== sv/rmfh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmfh_pkg
// Types, status codes and helpers shared by the recursive lock block.
// ----------------------------------------------------------------------------
package rmfh_pkg;

  // Thread ids above the supported range wrap modulo this count
  localparam int MAX_THREADS = 16;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [3:0] ST_GOT_FREE       = 4'd0;
  localparam logic [3:0] ST_RECURSIVE      = 4'd1;
  localparam logic [3:0] ST_QUEUED         = 4'd2;
  localparam logic [3:0] ST_STILL_HELD     = 4'd3;
  localparam logic [3:0] ST_NOW_FREE       = 4'd4;
  localparam logic [3:0] ST_HANDED_OFF     = 4'd5;
  localparam logic [3:0] ST_NOT_OWNER      = 4'd6;
  localparam logic [3:0] ST_QUEUE_FULL     = 4'd7;
  localparam logic [3:0] ST_DEPTH_OVERFLOW = 4'd8;

  typedef struct packed {
    logic       operation;
    logic [3:0] thread_id;
  } rmfh_req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [3:0] wake_thread;
    logic       owner_valid;
    logic [3:0] owner_thread;
    logic [7:0] hold_depth;
    logic [4:0] waiter_total;
  } rmfh_rsp_t;

  // Reduce a thread id modulo MAX_THREADS by repeated subtraction
  function automatic logic [3:0] tid_wrap(input logic [3:0] tid);
    logic [8:0] v;
    v = {5'b0, tid};
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(MAX_THREADS)) begin
        v = v - 9'(MAX_THREADS);
      end
    end
    return v[3:0];
  endfunction

endpackage

// ===== sv/rmfh_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmfh_req_if / rmfh_rsp_if
// Valid/ready channels for lock requests and lock responses.
// ----------------------------------------------------------------------------
interface rmfh_req_if;
  logic                 valid;
  logic                 ready;
  rmfh_pkg::rmfh_req_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface rmfh_rsp_if;
  logic                 valid;
  logic                 ready;
  rmfh_pkg::rmfh_rsp_t rsp;

  modport source (output valid, output rsp, input ready);
  modport sink   (input valid, input rsp, output ready);
endinterface

// ===== sv/recursive_mutex_fifo_handoff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff
// Recursive lock with a FIFO of waiting threads and hand-off on release.
// ----------------------------------------------------------------------------
// A request is registered on acceptance and decided in the execute state; its response
// is registered once the output is empty or being taken. New requests are accepted only
//   in the idle state. The queue head is read from waiter memory into a register.
// Reset: synchronous, active low; the lock is free and the waiter queue empty.
//   Waiter memory contents are not cleared; only queued entries are read.
module recursive_mutex_fifo_handoff #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DEPTH_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  rmfh_req_if.sink           in_if,
  rmfh_rsp_if.source         out_if
);
  import rmfh_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  // Lock state
  logic                  held_r, held_nxt;
  logic [3:0]            owner_r, owner_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // Waiter memory
  logic [3:0]            wq_mem [QUEUE_DEPTH];
  logic [3:0]            wq_rd_r;
  logic                  wq_we;

  logic [3:0]            req_op_tid_r;
  logic                  req_op_r;

  rmfh_rsp_t             rsp_r, rsp_nxt;
  logic                  out_valid_r;

  logic                  in_acc;
  logic                  exec_done;
  logic [3:0]            status;
  logic [3:0]            wake;
  logic                  queue_full;
  logic [DEPTH_BITS+7:0] depth_ext;
  logic [CNT_W+4:0]      cnt_ext;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_acc    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign exec_done = (state_r == S_EXEC) && (!out_valid_r || out_if.ready);
  assign queue_full = (cnt_r == CNT_W'(QUEUE_DEPTH));

  // Decide the request against the current lock state
  always_comb begin
    held_nxt  = held_r;
    owner_nxt = owner_r;
    depth_nxt = depth_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    wake      = 4'd0;
    wq_we     = 1'b0;
    if (req_op_r == OP_ACQUIRE) begin
      priority if (!held_r) begin
        held_nxt  = 1'b1;
        owner_nxt = req_op_tid_r;
        depth_nxt = DEPTH_BITS'(1);
        status    = ST_GOT_FREE;
      end else if (owner_r == req_op_tid_r) begin
        if (depth_r == '1) begin
          status = ST_DEPTH_OVERFLOW;
        end else begin
          depth_nxt = depth_r + DEPTH_BITS'(1);
          status    = ST_RECURSIVE;
        end
      end else if (queue_full) begin
        status = ST_QUEUE_FULL;
      end else begin
        wq_we    = 1'b1;
        tail_nxt = next_slot(tail_r);
        cnt_nxt  = cnt_r + CNT_W'(1);
        status   = ST_QUEUED;
      end
    end else begin
      priority if (!held_r || owner_r != req_op_tid_r) begin
        status = ST_NOT_OWNER;
      end else if (depth_r > DEPTH_BITS'(1)) begin
        depth_nxt = depth_r - DEPTH_BITS'(1);
        status    = ST_STILL_HELD;
      end else if (cnt_r == '0) begin
        held_nxt  = 1'b0;
        owner_nxt = 4'd0;
        depth_nxt = '0;
        status    = ST_NOW_FREE;
      end else begin
        wake      = wq_rd_r;
        head_nxt  = next_slot(head_r);
        cnt_nxt   = cnt_r - CNT_W'(1);
        owner_nxt = wq_rd_r;
        depth_nxt = DEPTH_BITS'(1);
        status    = ST_HANDED_OFF;
      end
    end
  end

  // Build the response from the post-step state
  always_comb begin
    depth_ext            = {8'b0, depth_nxt};
    cnt_ext              = {5'b0, cnt_nxt};
    rsp_nxt.status       = status;
    rsp_nxt.wake_thread  = wake;
    rsp_nxt.owner_valid  = held_nxt;
    rsp_nxt.owner_thread = owner_nxt;
    rsp_nxt.hold_depth   = depth_ext[7:0];
    rsp_nxt.waiter_total = cnt_ext[4:0];
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and lock state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= 1'b0;
      owner_r     <= 4'd0;
      depth_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_done) begin
        held_r      <= held_nxt;
        owner_r     <= owner_nxt;
        depth_r     <= depth_nxt;
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request and the response payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op_r     <= in_if.req.operation;
      req_op_tid_r <= tid_wrap(in_if.req.thread_id);
    end
    if (exec_done) begin
      rsp_r <= rsp_nxt;
    end
  end

  // Waiter memory: write the tail, read the head every cycle
  always_ff @(posedge clk) begin
    if (exec_done && wq_we) begin
      wq_mem[tail_r] <= req_op_tid_r;
    end
    wq_rd_r <= wq_mem[head_r];
  end

  assign out_if.valid = out_valid_r;
  assign out_if.rsp   = rsp_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("waiter count exceeds queue depth");

  a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (owner_r == 4'd0 && depth_r == '0))
    else $error("free lock carries owner or depth");

  a_held_depth: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> depth_r != '0)
    else $error("held lock with zero depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC)
    else $error("accepted transaction not executed");

  a_handoff_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rsp_r.status == ST_HANDED_OFF) |->
      (rsp_r.owner_thread == rsp_r.wake_thread && rsp_r.owner_valid))
    else $error("hand-off response disagrees with new owner");

endmodule
